[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SUE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SUE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sue_pkg.sv]
// shared types and constants of the string literal unescaper
`default_nettype none

package sue_pkg;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } phase_t;

    // status codes, all final but ST_RUN
    localparam logic [3:0] ST_RUN      = 4'd0;
    localparam logic [3:0] ST_DONE     = 4'd1;
    localparam logic [3:0] ST_NOQUOTE  = 4'd2;
    localparam logic [3:0] ST_UNTESC   = 4'd3;
    localparam logic [3:0] ST_BADHEX_X = 4'd4;
    localparam logic [3:0] ST_BADCP    = 4'd7;
    localparam logic [3:0] ST_BADESC   = 4'd8;
    localparam logic [3:0] ST_UNTSTR   = 4'd9;

    // escape kinds while gathering hex digits
    localparam logic [1:0] EK_NONE = 2'd0;
    localparam logic [1:0] EK_X    = 2'd1;
    localparam logic [1:0] EK_U4   = 2'd2;
    localparam logic [1:0] EK_U8   = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;

    localparam logic [31:0] CP_LIMIT = 32'h0011_0000;
    localparam logic [31:0] CP_2B    = 32'h0000_0080;
    localparam logic [31:0] CP_3B    = 32'h0000_0800;
    localparam logic [31:0] CP_4B    = 32'h0001_0000;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    // one unit of work handed from the front end to the back end
    typedef struct packed {
        logic        is_status;  // final status, no byte
        logic [3:0]  status;
        logic [1:0]  extra;      // bytes to send minus one
        logic [20:0] cp;         // raw byte or code point
    } job_t;

endpackage

`default_nettype wire

[rtl/sue_in_if.sv]
// input channel: raw literal bytes
`default_nettype none

interface sue_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/sue_out_if.sv]
// output channel: decoded bytes and final status
`default_nettype none

interface sue_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/sue_front.sv]
// front end: literal parser that turns input items into jobs
`default_nettype none

module sue_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accepted,
    input  wire logic            kind,
    input  wire logic [7:0]      data_byte,
    output sue_pkg::job_t        job,
    output logic                 job_push
);

    sue_pkg::phase_t phase_reg, phase_next;
    logic [31:0] hex_accum_reg, hex_accum_next;
    logic [3:0]  digits_left_reg, digits_left_next;
    logic [1:0]  escape_kind_reg, escape_kind_next;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [31:0] accum_shift;
    logic [3:0]  digits_dec;
    logic [1:0]  kind_eff;
    logic        has_job;

    // hex digit decode
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
            hex_val = data_byte[3:0];
        else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46))
            hex_val = data_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    // single-character escapes
    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        unique case (data_byte)
            8'h22:   esc_byte = 8'h22;
            8'h5C:   esc_byte = 8'h5C;
            8'h25:   esc_byte = 8'h25;
            8'h30:   esc_byte = 8'h00;
            8'h61:   esc_byte = 8'h07;
            8'h62:   esc_byte = 8'h08;
            8'h65:   esc_byte = 8'h1B;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            8'h76:   esc_byte = 8'h0B;
            default: esc_ok = 1'b0;
        endcase
    end

    assign accum_shift = {hex_accum_reg[27:0], hex_val};
    assign digits_dec  = (digits_left_reg != 4'd0) ? digits_left_reg - 4'd1 : 4'd0;
    assign kind_eff    = (escape_kind_reg == sue_pkg::EK_NONE) ? sue_pkg::EK_X
                                                               : escape_kind_reg;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        hex_accum_next   = hex_accum_reg;
        digits_left_next = digits_left_reg;
        escape_kind_next = escape_kind_reg;
        if (accepted)
        begin
            unique case (phase_reg)
                sue_pkg::PH_WAIT:
                begin
                    if (!kind && data_byte == sue_pkg::CH_QUOTE)
                        phase_next = sue_pkg::PH_BODY;
                    hex_accum_next   = '0;
                    digits_left_next = '0;
                    escape_kind_next = sue_pkg::EK_NONE;
                end
                sue_pkg::PH_BODY:
                begin
                    if (kind || data_byte == sue_pkg::CH_QUOTE)
                        phase_next = sue_pkg::PH_WAIT;
                    else if (data_byte == sue_pkg::CH_BSL)
                        phase_next = sue_pkg::PH_ESC;
                    if (kind || data_byte == sue_pkg::CH_QUOTE)
                    begin
                        hex_accum_next   = '0;
                        digits_left_next = '0;
                        escape_kind_next = sue_pkg::EK_NONE;
                    end
                end
                sue_pkg::PH_ESC:
                begin
                    hex_accum_next = '0;
                    if (kind)
                    begin
                        phase_next       = sue_pkg::PH_WAIT;
                        digits_left_next = '0;
                        escape_kind_next = sue_pkg::EK_NONE;
                    end
                    else if (esc_ok)
                    begin
                        phase_next     = sue_pkg::PH_BODY;
                        hex_accum_next = hex_accum_reg;
                    end
                    else if (data_byte == sue_pkg::CH_X)
                    begin
                        phase_next       = sue_pkg::PH_HEX;
                        escape_kind_next = sue_pkg::EK_X;
                        digits_left_next = 4'd2;
                    end
                    else if (data_byte == sue_pkg::CH_LU)
                    begin
                        phase_next       = sue_pkg::PH_HEX;
                        escape_kind_next = sue_pkg::EK_U4;
                        digits_left_next = 4'd4;
                    end
                    else if (data_byte == sue_pkg::CH_UU)
                    begin
                        phase_next       = sue_pkg::PH_HEX;
                        escape_kind_next = sue_pkg::EK_U8;
                        digits_left_next = 4'd8;
                    end
                    else
                    begin
                        phase_next       = sue_pkg::PH_WAIT;
                        digits_left_next = '0;
                        escape_kind_next = sue_pkg::EK_NONE;
                    end
                end
                sue_pkg::PH_HEX:
                begin
                    if (kind || !hex_ok)
                    begin
                        phase_next       = sue_pkg::PH_WAIT;
                        hex_accum_next   = '0;
                        digits_left_next = '0;
                        escape_kind_next = sue_pkg::EK_NONE;
                    end
                    else if (digits_dec != 4'd0)
                    begin
                        hex_accum_next   = accum_shift;
                        digits_left_next = digits_dec;
                    end
                    else
                    begin
                        hex_accum_next   = '0;
                        digits_left_next = '0;
                        escape_kind_next = sue_pkg::EK_NONE;
                        if (kind_eff != sue_pkg::EK_X && accum_shift >= sue_pkg::CP_LIMIT)
                            phase_next = sue_pkg::PH_WAIT;
                        else
                            phase_next = sue_pkg::PH_BODY;
                    end
                end
                default:
                    phase_next = sue_pkg::PH_WAIT;
            endcase
        end
    end

    // job output
    always_comb
    begin
        has_job = 1'b0;
        job     = '0;
        unique case (phase_reg)
            sue_pkg::PH_WAIT:
            begin
                if (kind || data_byte != sue_pkg::CH_QUOTE)
                begin
                    has_job       = 1'b1;
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_NOQUOTE;
                end
            end
            sue_pkg::PH_BODY:
            begin
                has_job = 1'b1;
                if (kind)
                begin
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_UNTSTR;
                end
                else if (data_byte == sue_pkg::CH_QUOTE)
                begin
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_DONE;
                end
                else if (data_byte == sue_pkg::CH_BSL)
                    has_job = 1'b0;
                else
                    job.cp = {13'd0, data_byte};
            end
            sue_pkg::PH_ESC:
            begin
                has_job = 1'b1;
                if (kind)
                begin
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_UNTESC;
                end
                else if (esc_ok)
                    job.cp = {13'd0, esc_byte};
                else if (data_byte == sue_pkg::CH_X || data_byte == sue_pkg::CH_LU ||
                         data_byte == sue_pkg::CH_UU)
                    has_job = 1'b0;
                else
                begin
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_BADESC;
                end
            end
            sue_pkg::PH_HEX:
            begin
                if (kind || !hex_ok)
                begin
                    has_job       = 1'b1;
                    job.is_status = 1'b1;
                    job.status    = sue_pkg::ST_BADHEX_X + {2'b00, kind_eff} - 4'd1;
                end
                else if (digits_dec == 4'd0)
                begin
                    has_job = 1'b1;
                    if (kind_eff == sue_pkg::EK_X)
                        job.cp = {13'd0, accum_shift[7:0]};
                    else if (accum_shift >= sue_pkg::CP_LIMIT)
                    begin
                        job.is_status = 1'b1;
                        job.status    = sue_pkg::ST_BADCP;
                    end
                    else
                    begin
                        job.cp = accum_shift[20:0];
                        if (accum_shift < sue_pkg::CP_2B)
                            job.extra = 2'd0;
                        else if (accum_shift < sue_pkg::CP_3B)
                            job.extra = 2'd1;
                        else if (accum_shift < sue_pkg::CP_4B)
                            job.extra = 2'd2;
                        else
                            job.extra = 2'd3;
                    end
                end
            end
            default:
                has_job = 1'b0;
        endcase
    end

    assign job_push = accepted && has_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sue_pkg::PH_WAIT;
            hex_accum_reg   <= '0;
            digits_left_reg <= '0;
            escape_kind_reg <= sue_pkg::EK_NONE;
        end
        else
        begin
            phase_reg       <= phase_next;
            hex_accum_reg   <= hex_accum_next;
            digits_left_reg <= digits_left_next;
            escape_kind_reg <= escape_kind_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sue_queue.sv]
// job queue between front end and back end
`default_nettype none

module sue_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sue_pkg::job_t push_job,
    input  wire logic          pop,
    output sue_pkg::job_t      head_job,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sue_pkg::job_t slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_job = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sue_back.sv]
// back end: expands jobs into result items, utf-8 encoding
`default_nettype none

module sue_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sue_pkg::job_t head_job,
    input  wire logic          q_empty,
    output logic               q_pop,
    sue_out_if.source          result
);

    sue_pkg::job_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic [3:0]    status_reg;
    logic          last_reg;

    logic          load_en;
    logic          emit;
    logic          job_end;
    logic [7:0]    sel_byte;
    logic [7:0]    cont_byte;

    assign load_en = !out_valid_reg || result.ready;
    assign emit    = load_en && cur_valid_reg;
    assign job_end = cur_reg.is_status || (idx_reg == cur_reg.extra);
    assign q_pop   = !q_empty && (!cur_valid_reg || (emit && job_end));

    // continuation byte for the current position, six bits of payload
    always_comb
    begin
        case (cur_reg.extra - idx_reg)
            2'd0:    cont_byte = sue_pkg::CONT_B | {2'b00, cur_reg.cp[5:0]};
            2'd1:    cont_byte = sue_pkg::CONT_B | {2'b00, cur_reg.cp[11:6]};
            default: cont_byte = sue_pkg::CONT_B | {2'b00, cur_reg.cp[17:12]};
        endcase
    end

    // lead byte on the first position, continuation after that
    always_comb
    begin
        sel_byte = cont_byte;
        if (idx_reg == 2'd0)
        begin
            case (cur_reg.extra)
                2'd0:    sel_byte = cur_reg.cp[7:0];
                2'd1:    sel_byte = sue_pkg::LEAD_2B | {3'b000, cur_reg.cp[10:6]};
                2'd2:    sel_byte = sue_pkg::LEAD_3B | {4'b0000, cur_reg.cp[15:12]};
                default: sel_byte = sue_pkg::LEAD_4B | {5'b00000, cur_reg.cp[20:18]};
            endcase
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (emit)
            idx_next = idx_reg + 2'd1;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (emit && job_end)
            cur_valid_next = 1'b0;
        out_valid_next = emit ? 1'b1 : (load_en ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= head_job;
        if (emit)
        begin
            out_byte_reg   <= cur_reg.is_status ? 8'h00 : sel_byte;
            byte_valid_reg <= !cur_reg.is_status;
            status_reg     <= cur_reg.is_status ? cur_reg.status : sue_pkg::ST_RUN;
            last_reg       <= job_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.byte_valid = byte_valid_reg;
    assign result.status     = status_reg;
    assign result.last       = last_reg;

endmodule

`default_nettype wire

[rtl/string_literal_unescaper_unit.sv]
// top level of the string literal unescaper
// path: a result passes the job queue, the current-job register and the output register
// throughput: one input item per cycle while the queue is not full; the back end sends
// one result per cycle unless stalled; the QUEUE_DEPTH job queue absorbs \u and \U escapes
// reset: rst_n clears the parser state, empties the queue and drops any pending result
`default_nettype none

module string_literal_unescaper_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sue_in_if.sink     literal,
    sue_out_if.source  result
);

    sue_pkg::job_t front_job;
    sue_pkg::job_t head_job;
    logic          job_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    logic          accepted;

    // the front end stalls only when the queue has no free slot
    assign literal.ready = !q_full;
    assign accepted      = literal.valid && literal.ready;

    // parser: one item per cycle while the queue is not full, at most one job out per item
    sue_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accepted  (accepted),
        .kind      (literal.kind),
        .data_byte (literal.data_byte),
        .job       (front_job),
        .job_push  (job_push)
    );

    // decouples the parser from the byte expansion
    sue_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // expansion into 1 to 4 bytes or a final status, registered output
    sue_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .result   (result)
    );

endmodule

`default_nettype wire

[rtl/sue_checker.sv]
// port-level checks on the result channel, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module sue_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] res_byte,
    input wire logic       res_byte_valid,
    input wire logic [3:0] res_status,
    input wire logic       res_last
);

    `SUE_ASSERT_NEXT(res_valid_held, res_valid && !res_ready, res_valid)
    `SUE_ASSERT_NEXT(res_payload_held, res_valid && !res_ready,
                     $stable(res_byte) && $stable(res_status) && $stable(res_last))
    `SUE_ASSERT_NOW(byte_is_running, res_valid && res_byte_valid,
                    res_status == sue_pkg::ST_RUN)
    `SUE_ASSERT_NOW(status_is_final, res_valid && !res_byte_valid,
                    res_last && res_byte == 8'h00 && res_status != sue_pkg::ST_RUN)

endmodule

bind string_literal_unescaper_unit sue_checker u_sue_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_byte       (result.out_byte),
    .res_byte_valid (result.byte_valid),
    .res_status     (result.status),
    .res_last       (result.last)
);

`default_nettype wire

[verif/string_literal_unescaper_unit_tb.sv]
// self-checking testbench of the string literal unescaper, directed and random literals
`default_nettype none

module string_literal_unescaper_unit_tb;

    // item kinds on the literal channel
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int RESET_CYCLES  = 4;
    // a result is registered after its item, plus some margin for the job queue
    localparam int SETTLE_CYCLES = 8;
    // worst case is far below this: ~550 items, at most four results each, 58% stalls
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 120;

    // one decoded byte or one final status, as the block should give it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] status;
        logic       last;
    } result_item_t;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic src_valid  = 1'b0;
    logic src_kind   = KIND_DATA;
    logic [7:0] src_byte = 8'h00;
    logic sink_ready = 1'b0;

    sue_in_if  literal_ch ();
    sue_out_if result_ch ();

    assign literal_ch.valid     = src_valid;
    assign literal_ch.kind      = src_kind;
    assign literal_ch.data_byte = src_byte;
    assign result_ch.ready      = sink_ready;

    string_literal_unescaper_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .literal (literal_ch),
        .result  (result_ch)
    );

    // decoder state mirrored on the testbench side
    sue_pkg::phase_t lit_phase = sue_pkg::PH_WAIT;
    logic [31:0] cp_accum  = 32'h0;
    logic [3:0]  hex_left  = 4'h0;
    logic [1:0]  esc_kind  = sue_pkg::EK_NONE;

    // result items still owed by the block, oldest first
    result_item_t due_q[$];

    // idling percentages of the current phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int unsigned cycle_count = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_bytes   = 0;
    int n_done    = 0;
    int n_err     = 0;
    int n_errors  = 0;

    // clock, period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run guard: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    function automatic void clear_state();
        cp_accum = 32'h0;
        hex_left = 4'h0;
        esc_kind = sue_pkg::EK_NONE;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic lst);
        result_item_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.status     = sue_pkg::ST_RUN;
        r.last       = lst;
        due_q.push_back(r);
    endfunction

    // any final status drops the decoder back to waiting for a quote
    function automatic void close_literal(input logic [3:0] st);
        result_item_t r;
        lit_phase    = sue_pkg::PH_WAIT;
        clear_state();
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.status     = st;
        r.last       = 1'b1;
        due_q.push_back(r);
    endfunction

    function automatic void start_hex(input logic [1:0] ek, input logic [3:0] ndig);
        esc_kind  = ek;
        hex_left  = ndig;
        cp_accum  = 32'h0;
        lit_phase = sue_pkg::PH_HEX;
    endfunction

    // bit 8 set when the character is a single-character escape
    function automatic logic [8:0] map_escape(input logic [7:0] e);
        case (e)
            sue_pkg::CH_QUOTE: return {1'b1, sue_pkg::CH_QUOTE};
            sue_pkg::CH_BSL:   return {1'b1, sue_pkg::CH_BSL};
            8'h25:    return {1'b1, 8'h25};  // percent sign
            8'h30:    return {1'b1, 8'h00};  // '0'
            8'h61:    return {1'b1, 8'h07};  // 'a' bell
            8'h62:    return {1'b1, 8'h08};  // 'b' backspace
            8'h65:    return {1'b1, 8'h1B};  // 'e' escape
            8'h66:    return {1'b1, 8'h0C};  // 'f' form feed
            8'h6E:    return {1'b1, 8'h0A};  // 'n'
            8'h72:    return {1'b1, 8'h0D};  // 'r'
            8'h74:    return {1'b1, 8'h09};  // 't'
            8'h76:    return {1'b1, 8'h0B};  // 'v'
            default:  return 9'h000;
        endcase
    endfunction

    // bit 4 set when the character is a hex digit of either case
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b1, c[3:0] + 4'd9};
        return 5'b0_0000;
    endfunction

    // work out the result items caused by one accepted item
    function automatic void decode_item(input logic k, input logic [7:0] c);
        logic [8:0]  esc;
        logic [4:0]  dig;
        logic [1:0]  ek;
        logic [31:0] cp;
        case (lit_phase)
            sue_pkg::PH_BODY:
            begin
                if (k == KIND_END)
                    close_literal(sue_pkg::ST_UNTSTR);
                else if (c == sue_pkg::CH_QUOTE)
                    close_literal(sue_pkg::ST_DONE);
                else if (c == sue_pkg::CH_BSL)
                    lit_phase = sue_pkg::PH_ESC;
                else
                    push_byte(c, 1'b1);
            end
            sue_pkg::PH_ESC:
            begin
                esc = map_escape(c);
                if (k == KIND_END)
                    close_literal(sue_pkg::ST_UNTESC);
                else if (esc[8])
                begin
                    lit_phase = sue_pkg::PH_BODY;
                    push_byte(esc[7:0], 1'b1);
                end
                else if (c == sue_pkg::CH_X)
                    start_hex(sue_pkg::EK_X, 4'd2);
                else if (c == sue_pkg::CH_LU)
                    start_hex(sue_pkg::EK_U4, 4'd4);
                else if (c == sue_pkg::CH_UU)
                    start_hex(sue_pkg::EK_U8, 4'd8);
                else
                    close_literal(sue_pkg::ST_BADESC);
            end
            sue_pkg::PH_HEX:
            begin
                ek  = (esc_kind == sue_pkg::EK_NONE) ? sue_pkg::EK_X : esc_kind;
                dig = hex_val(c);
                // bad digit status follows the escape kind: x, then u, then U
                if (k == KIND_END || !dig[4])
                    close_literal(sue_pkg::ST_BADHEX_X + {2'b00, ek} - 4'd1);
                else
                begin
                    cp_accum = {cp_accum[27:0], dig[3:0]};
                    if (hex_left != 4'h0)
                        hex_left = hex_left - 4'd1;
                    if (hex_left == 4'h0)
                    begin
                        cp        = cp_accum;
                        lit_phase = sue_pkg::PH_BODY;
                        cp_accum  = 32'h0;
                        esc_kind  = sue_pkg::EK_NONE;
                        if (ek == sue_pkg::EK_X)
                            push_byte(cp[7:0], 1'b1);
                        else if (cp >= sue_pkg::CP_LIMIT)
                            close_literal(sue_pkg::ST_BADCP);
                        else if (cp < sue_pkg::CP_2B)
                            push_byte(cp[7:0], 1'b1);
                        else if (cp < sue_pkg::CP_3B)
                        begin
                            push_byte(sue_pkg::LEAD_2B | {3'b000, cp[10:6]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[5:0]}, 1'b1);
                        end
                        else if (cp < sue_pkg::CP_4B)
                        begin
                            // surrogates land here too, three bytes like any other
                            push_byte(sue_pkg::LEAD_3B | {4'h0, cp[15:12]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[11:6]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[5:0]}, 1'b1);
                        end
                        else
                        begin
                            push_byte(sue_pkg::LEAD_4B | {5'b00000, cp[20:18]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[17:12]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[11:6]}, 1'b0);
                            push_byte(sue_pkg::CONT_B | {2'b00, cp[5:0]}, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                // only an opening quote leaves the waiting phase quietly
                if (k == KIND_END || c != sue_pkg::CH_QUOTE)
                    close_literal(sue_pkg::ST_NOQUOTE);
                else
                begin
                    lit_phase = sue_pkg::PH_BODY;
                    clear_state();
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        n_errors++;
        $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
            note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    function automatic void check_result();
        result_item_t want;
        result_item_t got;
        got.out_byte   = result_ch.out_byte;
        got.byte_valid = result_ch.byte_valid;
        got.status     = result_ch.status;
        got.last       = result_ch.last;
        n_results++;
        if (got.byte_valid)
            n_bytes++;
        else if (got.status == sue_pkg::ST_DONE)
            n_done++;
        else
            n_err++;
        if (due_q.size() == 0)
        begin
            note_failure($sformatf({"result item with nothing expected: ",
                                    "byte %0h valid %0b status %0d last %0b"},
                                   got.out_byte, got.byte_valid, got.status, got.last));
            return;
        end
        want = due_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("status", want.status, got.status);
        check_field("last", want.last, got.last);
    endfunction

    // receiver: take each result item, then choose whether to stall the next edge
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // one item on the literal channel; returns at the edge that accepts it,
    // with valid still high so that a following item needs no gap
    task automatic send_item(input logic k, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_kind  <= k;
        src_byte  <= b;
        @(posedge clk);
        while (!literal_ch.ready)
            @(posedge clk);
        decode_item(k, b);
        n_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(KIND_DATA, b);
    endtask

    // end of buffer; the byte field is don't-care, so it is randomised
    task automatic send_end();
        send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    // hold the sender off until every owed result item has arrived
    task automatic wait_all_results();
        src_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] d;
        if ($urandom_range(3) == 0)
            return sue_pkg::CH_QUOTE;
        b = 8'($urandom_range(255));
        d = hex_val(b);
        while (d[4])
        begin
            b = 8'($urandom_range(255));
            d = hex_val(b);
        end
        return b;
    endfunction

    // body byte that neither closes the literal nor starts an escape
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == sue_pkg::CH_QUOTE || b == sue_pkg::CH_BSL)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] esc_letter(input int i);
        case (i)
            0:       return sue_pkg::CH_QUOTE;
            1:       return sue_pkg::CH_BSL;
            2:       return 8'h25;
            3:       return 8'h30;
            4:       return 8'h61;
            5:       return 8'h62;
            6:       return 8'h65;
            7:       return 8'h66;
            8:       return 8'h6E;
            9:       return 8'h72;
            10:      return 8'h74;
            default: return 8'h76;
        endcase
    endfunction

    // spread over every utf-8 length, the out-of-range region and the boundaries
    function automatic logic [31:0] pick_code_point();
        case ($urandom_range(5))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3: return $urandom_range(32'h10FFFF, 32'h10000);
            4: return $urandom_range(32'hFFFFFFFF, sue_pkg::CP_LIMIT);
            default:
            begin
                case ($urandom_range(11))
                    0:       return 32'h0;
                    1:       return sue_pkg::CP_2B - 32'd1;
                    2:       return sue_pkg::CP_2B;
                    3:       return sue_pkg::CP_3B - 32'd1;
                    4:       return sue_pkg::CP_3B;
                    5:       return 32'h0000_D800;
                    6:       return 32'h0000_DFFF;
                    7:       return sue_pkg::CP_4B - 32'd1;
                    8:       return sue_pkg::CP_4B;
                    9:       return sue_pkg::CP_LIMIT - 32'd1;
                    10:      return sue_pkg::CP_LIMIT;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // backslash, letter, hex digits msb first; brk >= 0 spoils that digit
    task automatic send_hex_escape(input logic [7:0] letter, input int ndig,
                                   input logic [31:0] val, input int brk);
        int i;
        send_data(sue_pkg::CH_BSL);
        send_data(letter);
        for (i = ndig - 1; i >= 0; i--)
        begin
            if (i == brk)
            begin
                if ($urandom_range(2) == 0)
                    send_end();
                else
                    send_data(non_hex_byte());
                return;
            end
            send_data(hex_char(val[4*i +: 4]));
        end
    endtask

    task automatic send_token();
        case ($urandom_range(8))
            0, 1, 2, 3:
                send_data(plain_byte());
            4, 5:
            begin
                send_data(sue_pkg::CH_BSL);
                send_data(esc_letter($urandom_range(11)));
            end
            6:
                send_hex_escape(sue_pkg::CH_X, 2, $urandom_range(255), -1);
            7:
                send_hex_escape(sue_pkg::CH_LU, 4, pick_code_point() & 32'h0000_FFFF, -1);
            default:
                send_hex_escape(sue_pkg::CH_UU, 8, pick_code_point(), -1);
        endcase
    endtask

    // a literal most often cut short: end of buffer, dangling escape, escape of a random character, bad hex
    task automatic send_break();
        int k;
        int ndig;
        logic [7:0] letter;
        case ($urandom_range(3))
            0:
                send_end();
            1:
            begin
                send_data(sue_pkg::CH_BSL);
                send_end();
            end
            2:
            begin
                send_data(sue_pkg::CH_BSL);
                send_data(8'($urandom_range(255)));
            end
            default:
            begin
                k      = $urandom_range(2);
                letter = (k == 0) ? sue_pkg::CH_X : (k == 1) ? sue_pkg::CH_LU : sue_pkg::CH_UU;
                ndig   = (k == 0) ? 2 : (k == 1) ? 4 : 8;
                send_hex_escape(letter, ndig, $urandom, $urandom_range(ndig - 1));
            end
        endcase
    endtask

    // mostly well-formed literals, a few of them broken off
    task automatic send_literal();
        int ntok;
        int i;
        send_data(sue_pkg::CH_QUOTE);
        ntok = $urandom_range(6);
        for (i = 0; i < ntok; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_break();
                return;
            end
            send_token();
        end
        if ($urandom_range(9) == 0)
            send_break();
        else
            send_data(sue_pkg::CH_QUOTE);
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // anything but a quote while waiting, including the end of the buffer
    task automatic test_outside_literal();
        send_end();
        send_data(8'h00);
    endtask

    // top byte passes through, a fixed escape, then an unknown escape character
    task automatic test_plain_and_simple_escapes();
        send_data(sue_pkg::CH_QUOTE);
        send_data(8'hFF);
        send_data(sue_pkg::CH_BSL);
        send_data(8'h65);
        send_data(sue_pkg::CH_BSL);
        send_data(8'h71);
    endtask

    // buffer ends just after a backslash, then inside a plain body
    task automatic test_unterminated();
        send_data(sue_pkg::CH_QUOTE);
        send_data(8'h00);
        send_data(sue_pkg::CH_BSL);
        send_end();
        send_data(sue_pkg::CH_QUOTE);
        send_end();
    endtask

    // a surrogate code point, then a quote where a hex digit belongs
    task automatic test_hex_escapes();
        send_data(sue_pkg::CH_QUOTE);
        send_hex_escape(sue_pkg::CH_LU, 4, 32'h0000_D800, -1);
        send_data(sue_pkg::CH_BSL);
        send_data(sue_pkg::CH_X);
        send_data(sue_pkg::CH_QUOTE);
    endtask

    task automatic test_random_literals(input int src_pct, input int snk_pct, input int n);
        int stop_at;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        stop_at        = n_sent + n;
        while (n_sent < stop_at)
        begin
            // noise between literals: stray bytes or buffer ends
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(3) == 0)
                    send_end();
                else
                    send_data(8'($urandom_range(255)));
            end
            else
                send_literal();
            // now and then let the block run completely dry
            if ($urandom_range(24) == 0)
                wait_all_results();
        end
        wait_all_results();
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outside_literal();
        test_plain_and_simple_escapes();
        test_unterminated();
        test_hex_escapes();
        wait_all_results();

        // idling patterns: none, sender gaps, receiver stalls, a little of both
        test_random_literals(0, 0, RANDOM_ITEMS);
        test_random_literals(58, 0, RANDOM_ITEMS);
        test_random_literals(0, 58, RANDOM_ITEMS);
        test_random_literals(10, 10, RANDOM_ITEMS);

        $display("run: %0d items in, %0d result items checked (%0d bytes, %0d closed, %0d errors)",
                 n_sent, n_results, n_bytes, n_done, n_err);
        $display("run: plain bytes, fixed escapes, x/u/U escapes of every utf-8 length, "
                 , "every error status, under four idling patterns");
        if (n_errors == 0 && due_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
